// ===== rtl/irt_pkg.sv =====
// Shared types, codes and a byte-swap helper for the interface route table.
package irt_pkg;

	// Request operation codes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_ROUTE = 2'd1;
	localparam logic [1:0] OP_EXACT = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_DEFAULT = 2'd1;
	localparam logic [1:0] STATUS_NONE    = 2'd2;
	localparam logic [1:0] STATUS_FULL    = 2'd3;

	// One stored interface: words already byte-swapped
	typedef struct packed {
		logic [31:0] address;
		logic [31:0] mask;
		logic [31:0] gateway;
	} entry_t;

	// Lookup token that walks the cell chain
	typedef struct packed {
		logic        valid;
		logic        route;
		logic [31:0] query;
		logic        hit;
		logic        def_seen;
		logic [2:0]  idx;
		logic [31:0] gw;
		logic [2:0]  def_idx;
		logic [31:0] def_gw;
	} token_t;

	function automatic logic [31:0] swap_bytes(input logic [31:0] v);
		swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

// ===== rtl/irt_cell.sv =====
// One table slot: holds an entry and checks the passing lookup token against it.
module irt_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             occ,
	input  logic             wr_sel,
	input  irt_pkg::entry_t  wr_entry,
	input  irt_pkg::token_t  tok_in,
	output irt_pkg::token_t  tok_out
);

	localparam logic [2:0] IDX3 = 3'(IDX);

	irt_pkg::entry_t ent_q;
	irt_pkg::token_t tok_q;
	irt_pkg::token_t nxt;
	logic            valid_q;
	logic            hit_now;

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			ent_q <= wr_entry;
		end
	end

	always_comb begin
		if (tok_in.route) begin
			hit_now = (ent_q.mask & ent_q.address) == (ent_q.mask & tok_in.query);
		end else begin
			hit_now = ent_q.address == tok_in.query;
		end
		nxt = tok_in;
		if (tok_in.valid && occ) begin
			// first hit wins: cells are visited newest first
			if (!tok_in.hit && hit_now) begin
				nxt.hit = 1'b1;
				nxt.idx = IDX3;
				nxt.gw  = ent_q.gateway;
			end
			// first occupied cell is the newest entry
			if (!tok_in.def_seen) begin
				nxt.def_seen = 1'b1;
				nxt.def_idx  = IDX3;
				nxt.def_gw   = ent_q.gateway;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= nxt;
		end
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end

endmodule

// ===== rtl/interface_route_table_unit.sv =====
// Top level of the interface route table: slot allocation, cell chain and result register.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  request | in_valid, in_ready, op, query_address, subnet_mask,  | into block
//          | gateway_address                                      |
//  result  | out_valid, out_ready, status, entry_index,           | out of block
//          | entry_gateway                                        |
//
//  Timing: an add, an unused opcode or a lookup on an empty table answers in the
//  cycle after acceptance. A lookup walks a token through TABLE_DEPTH cells, one per
//  cycle while the chain is not held, and its result is registered from the last
//  cell. One request is in flight at a time.
//  Reset: arst_n clears the fill count, the token valid bits, the state and the
//  result valid flag; the stored entries and the result fields keep whatever they held.
//  Stalls: a held result blocks new requests; a finished token waits in the last
//  cell, with the whole chain held, until the result register frees.
module interface_route_table_unit #(
	parameter int TABLE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] query_address,
	input  logic [31:0] subnet_mask,
	input  logic [31:0] gateway_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [2:0]  entry_index,
	output logic [31:0] entry_gateway
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t state_q;
	logic [CW-1:0] used_q;

	logic out_valid_q;
	logic [1:0] status_q;
	logic [2:0] entry_index_q;
	logic [31:0] entry_gateway_q;

	logic in_acc;
	logic full;
	logic [CW-1:0] slot_wide;
	logic [IW-1:0] slot;
	logic [IW+2:0] slot_ext;
	logic [2:0] slot3;
	logic do_add;
	logic do_scan;
	logic [1:0] imm_status;
	logic [2:0] imm_index;
	logic [31:0] imm_gw;

	irt_pkg::entry_t wr_entry;
	irt_pkg::token_t tok_w [0:TABLE_DEPTH];
	irt_pkg::token_t tail;
	logic [TABLE_DEPTH-1:0] occ;
	logic [TABLE_DEPTH-1:0] wr_sel;
	logic adv;
	logic tail_load;
	logic [1:0] scan_status;
	logic [2:0] scan_index;
	logic [31:0] scan_gw;

	// Accept only while idle and with room in the result register
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_acc   = in_valid && in_ready;

	// Slots are handed out from the top index downward
	assign full      = used_q == CW'(TABLE_DEPTH);
	assign slot_wide = CW'(TABLE_DEPTH - 1) - used_q;
	assign slot      = slot_wide[IW-1:0];
	assign slot_ext  = (IW + 3)'(slot);
	assign slot3     = slot_ext[2:0];

	assign wr_entry.address = irt_pkg::swap_bytes(query_address);
	assign wr_entry.mask    = irt_pkg::swap_bytes(subnet_mask);
	assign wr_entry.gateway = irt_pkg::swap_bytes(gateway_address);

	// Decode the request: either answer at once or launch a token
	always_comb begin
		do_add     = 1'b0;
		do_scan    = 1'b0;
		imm_status = irt_pkg::STATUS_NONE;
		imm_index  = 3'd0;
		imm_gw     = 32'd0;
		unique case (op)
			irt_pkg::OP_ADD: begin
				if (full) begin
					imm_status = irt_pkg::STATUS_FULL;
				end else begin
					do_add     = 1'b1;
					imm_status = irt_pkg::STATUS_OK;
					imm_index  = slot3;
					imm_gw     = wr_entry.gateway;
				end
			end
			irt_pkg::OP_ROUTE, irt_pkg::OP_EXACT: begin
				do_scan = used_q != '0;
			end
			default: begin
				imm_status = irt_pkg::STATUS_NONE;
			end
		endcase
	end

	// Token entering the first cell
	always_comb begin
		tok_w[0]          = '0;
		tok_w[0].valid    = in_acc && do_scan;
		tok_w[0].route    = op == irt_pkg::OP_ROUTE;
		tok_w[0].query    = query_address;
	end

	// Hold the whole chain while a finished token waits on the result register
	assign tail      = tok_w[TABLE_DEPTH];
	assign adv       = !(tail.valid && out_valid_q && !out_ready);
	assign tail_load = tail.valid && (!out_valid_q || out_ready);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		// a slot is occupied once the fill has reached down to it
		assign occ[i]    = CW'(i) >= (CW'(TABLE_DEPTH) - used_q);
		assign wr_sel[i] = in_acc && do_add && (slot == IW'(i));

		irt_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.occ      (occ[i]),
			.wr_sel   (wr_sel[i]),
			.wr_entry (wr_entry),
			.tok_in   (tok_w[i]),
			.tok_out  (tok_w[i+1])
		);
	end

	// Resolve the finished token: hit, else newest entry for a route lookup, else none
	always_comb begin
		priority if (tail.hit) begin
			scan_status = irt_pkg::STATUS_OK;
			scan_index  = tail.idx;
			scan_gw     = tail.gw;
		end else if (tail.route && tail.def_seen) begin
			scan_status = irt_pkg::STATUS_DEFAULT;
			scan_index  = tail.def_idx;
			scan_gw     = tail.def_gw;
		end else begin
			scan_status = irt_pkg::STATUS_NONE;
			scan_index  = 3'd0;
			scan_gw     = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && do_scan) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tail_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Advance the fill count on every accepted add into a table with room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (in_acc && do_add) begin
			used_q <= used_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_acc && !do_scan) || tail_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && !do_scan) begin
			status_q        <= imm_status;
			entry_index_q   <= imm_index;
			entry_gateway_q <= imm_gw;
		end else if (tail_load) begin
			status_q        <= scan_status;
			entry_index_q   <= scan_index;
			entry_gateway_q <= scan_gw;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign entry_index   = entry_index_q;
	assign entry_gateway = entry_gateway_q;

	// No token may still be in the chain when a new request can be taken
	a_idle_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !tail.valid)
		else $error("request accepted while a lookup token is in flight");

	// Fill count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	// An accepted add into a table with room bumps the count by one
	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && do_add) |=> (used_q == $past(used_q) + CW'(1)))
		else $error("add did not advance fill count");

	// A finished token that loads the result returns the block to idle
	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		tail_load |=> (state_q == ST_IDLE) && out_valid_q)
		else $error("lookup finish did not return to idle");

endmodule

// ===== tb/interface_route_table_checker.sv =====
// Channel monitor, route table predictor and result comparison for the interface route table.
`timescale 1ns / 1ps

module interface_route_table_checker #(
	parameter int TABLE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] query_address,
	input  logic [31:0] subnet_mask,
	input  logic [31:0] gateway_address,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [2:0]  entry_index,
	input  logic [31:0] entry_gateway,
	output int          fail_count,
	output int          pending,
	output int          checked_count
);

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  index;
		logic [31:0] gateway;
	} answer_t;

	// Predicted table contents, held in stored (swapped) byte order
	logic [31:0] tbl_addr [TABLE_DEPTH];
	logic [31:0] tbl_mask [TABLE_DEPTH];
	logic [31:0] tbl_gw   [TABLE_DEPTH];
	int          fill;
	answer_t     answers_due [$];

	initial begin
		fail_count    = 0;
		pending       = 0;
		checked_count = 0;
		fill          = 0;
	end

	function automatic logic [31:0] byte_reverse(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	// Apply one request to the predicted table and return the answer it earns
	function automatic answer_t table_response(input logic [1:0] code, input logic [31:0] q,
			input logic [31:0] m, input logic [31:0] g);
		answer_t r;
		int      slot;
		int      newest;
		logic    found;
		r.status  = irt_pkg::STATUS_NONE;
		r.index   = 3'd0;
		r.gateway = 32'd0;
		found     = 1'b0;
		case (code)
			irt_pkg::OP_ADD: begin
				if (fill >= TABLE_DEPTH) begin
					r.status = irt_pkg::STATUS_FULL;
				end else begin
					slot           = TABLE_DEPTH - 1 - fill;
					tbl_addr[slot] = byte_reverse(q);
					tbl_mask[slot] = byte_reverse(m);
					tbl_gw[slot]   = byte_reverse(g);
					fill++;
					r.status  = irt_pkg::STATUS_OK;
					r.index   = slot[2:0];
					r.gateway = tbl_gw[slot];
				end
			end
			irt_pkg::OP_ROUTE, irt_pkg::OP_EXACT: begin
				if (fill > 0) begin
					newest = TABLE_DEPTH - fill;
					for (slot = newest; slot < TABLE_DEPTH && !found; slot++) begin
						if (code == irt_pkg::OP_ROUTE)
							found = (tbl_mask[slot] & tbl_addr[slot]) == (tbl_mask[slot] & q);
						else
							found = tbl_addr[slot] == q;
						if (found) begin
							r.status  = irt_pkg::STATUS_OK;
							r.index   = slot[2:0];
							r.gateway = tbl_gw[slot];
						end
					end
					if (!found && code == irt_pkg::OP_ROUTE) begin
						r.status  = irt_pkg::STATUS_DEFAULT;
						r.index   = newest[2:0];
						r.gateway = tbl_gw[newest];
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			fill = 0;
			answers_due.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: result with no request waiting: status %0d index %0d gateway %h",
						$time, status, entry_index, entry_gateway);
					fail_count++;
				end else begin
					want = answers_due.pop_front();
					checked_count++;
					if (status !== want.status) begin
						$display("%0t: status expected %0d, got %0d", $time, want.status, status);
						fail_count++;
					end
					if (entry_index !== want.index) begin
						$display("%0t: entry_index expected %0d, got %0d",
							$time, want.index, entry_index);
						fail_count++;
					end
					if (entry_gateway !== want.gateway) begin
						$display("%0t: entry_gateway expected %h, got %h",
							$time, want.gateway, entry_gateway);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				answers_due.push_back(table_response(op, query_address, subnet_mask,
					gateway_address));
			pending = answers_due.size();
		end
	end

endmodule

// ===== tb/interface_route_table_unit_tb.sv =====
// Top of the interface route table testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module interface_route_table_unit_tb;

	localparam int         TABLE_DEPTH     = 8;
	localparam logic [1:0] OP_SPARE        = 2'd3;   // opcode the block does not define
	localparam int         HOLD_OFF_CYCLES = 300;
	localparam int         CYCLE_LIMIT     = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [31:0] query_address;
	logic [31:0] subnet_mask;
	logic [31:0] gateway_address;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [2:0]  entry_index;
	logic [31:0] entry_gateway;

	int fail_count;
	int pending;
	int checked_count;

	// Idling knobs, read by the sender task and the receiver process
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_off_req   = 1'b0;

	// Raw words of every entry that went into the table, in order of addition,
	// so that lookups can be aimed at real entries
	logic [31:0] entry_addr_raw [TABLE_DEPTH];
	logic [31:0] entry_mask_raw [TABLE_DEPTH];
	int          entries_added = 0;

	int adds_sent   = 0;
	int routes_sent = 0;
	int exacts_sent = 0;
	int spares_sent = 0;
	int cycle_count = 0;

	interface_route_table_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.query_address   (query_address),
		.subnet_mask     (subnet_mask),
		.gateway_address (gateway_address),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.entry_index     (entry_index),
		.entry_gateway   (entry_gateway)
	);

	interface_route_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.query_address   (query_address),
		.subnet_mask     (subnet_mask),
		.gateway_address (gateway_address),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.entry_index     (entry_index),
		.entry_gateway   (entry_gateway),
		.fail_count      (fail_count),
		.pending         (pending),
		.checked_count   (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Guard against a hung handshake: give up well past the slowest correct run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
		$display("[interface_route_table_unit] ERROR");
		$finish;
	end

	// Result side: stall at random, and once hold off for a long stretch so that
	// the block backs up and drops in_ready while requests keep coming
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic logic [31:0] byte_reverse(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	// Offer one request, entered and left at a falling edge. Idle first if the
	// dice say so, then hold valid and payload steady until the block takes it.
	task automatic offer_request(input logic [1:0] code, input logic [31:0] q,
			input logic [31:0] m, input logic [31:0] g);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
		end
		in_valid        <= 1'b1;
		op              <= code;
		query_address   <= q;
		subnet_mask     <= m;
		gateway_address <= g;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		case (code)
			irt_pkg::OP_ADD:   adds_sent++;
			irt_pkg::OP_ROUTE: routes_sent++;
			irt_pkg::OP_EXACT: exacts_sent++;
			default:           spares_sent++;
		endcase
	endtask

	// Add an interface and remember its raw words while the table has room
	task automatic add_entry(input logic [31:0] a, input logic [31:0] m, input logic [31:0] g);
		if (entries_added < TABLE_DEPTH) begin
			entry_addr_raw[entries_added] = a;
			entry_mask_raw[entries_added] = m;
			entries_added++;
		end
		offer_request(irt_pkg::OP_ADD, a, m, g);
	endtask

	// Mostly lookups aimed at stored entries, with misses, rejected adds and
	// the spare opcode mixed in. The table is full by now.
	task automatic random_request();
		int          pick;
		int          k;
		logic [31:0] sa;
		logic [31:0] sm;
		pick = $urandom_range(0, 99);
		k    = $urandom_range(0, entries_added - 1);
		sa   = byte_reverse(entry_addr_raw[k]);
		sm   = byte_reverse(entry_mask_raw[k]);
		if (pick < 8)
			offer_request(irt_pkg::OP_ADD, $urandom,
				($urandom_range(0, 3) == 0) ? 32'd0 : $urandom, $urandom);
		else if (pick < 45)
			// same subnet as entry k, random host bits
			offer_request(irt_pkg::OP_ROUTE, (sa & sm) | ($urandom & ~sm), $urandom, $urandom);
		else if (pick < 60)
			offer_request(irt_pkg::OP_ROUTE, $urandom, $urandom, $urandom);
		else if (pick < 80)
			offer_request(irt_pkg::OP_EXACT, sa, $urandom, $urandom);
		else if (pick < 95)
			// one bit off a stored address, or anything at all
			offer_request(irt_pkg::OP_EXACT, ($urandom_range(0, 1) == 0) ?
				(sa ^ (32'd1 << $urandom_range(0, 31))) : $urandom, $urandom, $urandom);
		else
			offer_request(OP_SPARE, $urandom, $urandom, $urandom);
	endtask

	task automatic run_phase(input int items, input int s_idle, input int r_stall);
		send_idle_pct  = s_idle;
		recv_stall_pct = r_stall;
		repeat (items) random_request();
	endtask

	initial begin
		logic [31:0] a1;
		in_valid        = 1'b0;
		op              = irt_pkg::OP_ADD;
		query_address   = 32'd0;
		subnet_mask     = 32'd0;
		gateway_address = 32'd0;
		arst_n          = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty table: both lookups and the spare opcode find nothing
		offer_request(irt_pkg::OP_ROUTE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		offer_request(irt_pkg::OP_EXACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer_request(OP_SPARE, $urandom, $urandom, $urandom);

		// Partly filled table: all-ones entry, a /24 and a /16 on address zero
		a1 = $urandom;
		add_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_entry(a1, 32'h00FF_FFFF, 32'h0000_0000);
		add_entry(32'h0000_0000, 32'h0000_FFFF, $urandom);

		// Lookup words stay raw, so aim with the swapped form of the address
		offer_request(irt_pkg::OP_ROUTE,
			(byte_reverse(a1) & 32'hFFFF_FF00) | ($urandom & 32'h0000_00FF),
			32'h0000_0000, 32'h0000_0000);
		offer_request(irt_pkg::OP_ROUTE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
		offer_request(irt_pkg::OP_ROUTE, 32'h5A5A_5A5A, $urandom, $urandom);   // newest entry
		offer_request(irt_pkg::OP_EXACT, byte_reverse(a1), $urandom, $urandom);
		offer_request(irt_pkg::OP_EXACT, 32'h0000_0001, $urandom, $urandom);

		// Fill up, with a newer duplicate of the /24 address as a host route
		add_entry(a1, 32'hFFFF_FFFF, $urandom);
		add_entry($urandom, 32'h0000_FFFF, $urandom);
		add_entry(32'h0000_0080, 32'h0000_00FF, $urandom);
		add_entry($urandom, $urandom | 32'h0000_0001, $urandom);
		add_entry($urandom, 32'h00FF_FFFF, $urandom);

		// Full table: adds bounce and leave the entries untouched
		add_entry(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		add_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);

		offer_request(irt_pkg::OP_EXACT, byte_reverse(a1), $urandom, $urandom);   // newest wins
		offer_request(irt_pkg::OP_ROUTE, byte_reverse(a1) ^ 32'h0000_0001, $urandom, $urandom);
		offer_request(irt_pkg::OP_ROUTE, byte_reverse(entry_addr_raw[TABLE_DEPTH - 1]),
			$urandom, $urandom);
		offer_request(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer_request(irt_pkg::OP_EXACT, 32'hFFFF_FFFF, $urandom, $urandom);
		offer_request(irt_pkg::OP_ROUTE, 32'h0000_0000, $urandom, $urandom);

		// Random traffic under each idling pattern
		run_phase(200, 0, 0);
		run_phase(160, 59, 0);
		run_phase(160, 0, 59);
		run_phase(160, 30, 30);

		// Long result hold-off with the sender pushing flat out behind it
		hold_off_req = 1'b1;
		run_phase(150, 0, 0);

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (TABLE_DEPTH + 8) @(negedge clk);

		$display("covered %0d adds, %0d route lookups, %0d address lookups, %0d spare opcodes",
			adds_sent, routes_sent, exacts_sent, spares_sent);
		$display("from empty through full table, %0d results checked, %0d failures",
			checked_count, fail_count + pending);
		if (fail_count == 0 && pending == 0)
			$display("[interface_route_table_unit] OK");
		else
			$display("[interface_route_table_unit] ERROR");
		$finish;
	end

endmodule
